// ----- hdl/ntat_pkg.sv -----
// Shared types and constants of the track association table.
`timescale 1ns / 1ps
package ntat_pkg;

	localparam int POS_W    = 16;
	localparam int HEIGHT_W = 10;
	localparam int TIME_W   = 32;
	localparam int SQ_W     = 32;   // |dx| <= 65535, so dx*dx fits 32 bits
	localparam int DIST_W   = 33;   // sum of two squares
	localparam int MD_W     = 10;
	localparam int MDSQ_W   = 20;
	localparam int TT_W     = 20;

	localparam logic [MD_W-1:0] MD_RESET = 10'd180;
	localparam logic [TT_W-1:0] TT_RESET = 20'd10000;

	localparam logic OP_DETECT = 1'b0;
	localparam logic OP_PURGE  = 1'b1;

	localparam logic REG_MATCH_DIST = 1'b0;
	localparam logic REG_TRACK_TIME = 1'b1;

	typedef enum logic [1:0] {
		ACT_UPDATE = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_DROP   = 2'd2,
		ACT_PURGE  = 2'd3
	} action_t;

	// One table row as stored in the entry memory.
	typedef struct packed {
		logic signed [POS_W-1:0]    x;
		logic signed [POS_W-1:0]    y;
		logic        [HEIGHT_W-1:0] height;
		logic signed [POS_W-1:0]    heading;
		logic        [TIME_W-1:0]   stamp;
	} entry_t;

	// Status of the distance pipeline.
	typedef struct packed {
		logic              valid;
		logic              busy;
		logic [DIST_W-1:0] sq_dist;
	} dist_out_t;

endpackage

// ----- hdl/ntat_ram.sv -----
// Generic single-clock RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module ntat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/ntat_dist.sv -----
// Two-stage squared x/y distance pipeline.
`timescale 1ns / 1ps
module ntat_dist (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic signed [ntat_pkg::POS_W-1:0]     entry_x,
	input  logic signed [ntat_pkg::POS_W-1:0]     entry_y,
	input  logic signed [ntat_pkg::POS_W-1:0]     pos_x,
	input  logic signed [ntat_pkg::POS_W-1:0]     pos_y,
	output ntat_pkg::dist_out_t                   res
);

	logic signed [ntat_pkg::POS_W:0]       dx, dy;
	logic signed [2*ntat_pkg::POS_W+1:0]   px2, py2;
	logic [ntat_pkg::SQ_W-1:0]             sq_x_s2, sq_y_s2;
	logic [ntat_pkg::DIST_W-1:0]           dist_s3;
	logic                                  v_s2, v_s3;

	assign dx  = {entry_x[ntat_pkg::POS_W-1], entry_x} - {pos_x[ntat_pkg::POS_W-1], pos_x};
	assign dy  = {entry_y[ntat_pkg::POS_W-1], entry_y} - {pos_y[ntat_pkg::POS_W-1], pos_y};
	assign px2 = dx * dx;
	assign py2 = dy * dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sq_x_s2 <= px2[ntat_pkg::SQ_W-1:0];
		sq_y_s2 <= py2[ntat_pkg::SQ_W-1:0];
		dist_s3 <= {1'b0, sq_x_s2} + {1'b0, sq_y_s2};
	end

	assign res.valid   = v_s3;
	assign res.busy    = v_s2 | v_s3;
	assign res.sq_dist = dist_s3;

endmodule

// ----- hdl/nearest_track_association_table_core.sv -----
// Top level of the nearest-neighbor track association table.
`timescale 1ns / 1ps
// A command is taken at a clock edge with start high and busy low. Opcode 0
// is a detection: every valid entry is read from the entry RAM in table
// order, one per cycle, and its squared x/y distance to the detection goes
// through a two-stage multiply/add pipeline; the first entry with the
// smallest distance wins. If that distance is below match_distance squared
// the entry is overwritten, else the detection is appended or dropped when
// the table is full. Opcode 1 is a purge: entries are read in order and the
// ones not older than tracking_time_ms are written back compacted, on the
// same RAM, one entry per cycle. The time a command takes grows with the
// number of valid entries, since all of them pass the single RAM read port.
// The result is shown for exactly one cycle with done high and must be
// taken then: there is no way to hold it. busy is low in that same cycle,
// so the next command may be started alongside it. Registers sit on the APB
// port: match_distance at 0x0, tracking_time_ms at 0x4; write them only
// while busy is low.
module nearest_track_association_table_core #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// command
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	input  logic [9:0]  obj_height,
	input  logic [15:0] heading,
	input  logic [31:0] frame_time_ms,
	// result
	output logic        done,
	output logic [1:0]  action,
	output logic [4:0]  slot,
	output logic [5:0]  removed,
	output logic [5:0]  entry_count,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DECIDE = 4'b0100,
		ST_PURGE  = 4'b1000
	} state_t;

	state_t state_q;

	// registers
	logic [ntat_pkg::MD_W-1:0]   md_q;
	logic [ntat_pkg::TT_W-1:0]   tt_q;
	logic [ntat_pkg::MDSQ_W-1:0] md_sq_q;

	// latched command
	logic                                    op_q;
	logic signed [ntat_pkg::POS_W-1:0]       pos_x_q, pos_y_q, heading_q;
	logic [ntat_pkg::HEIGHT_W-1:0]           height_q;
	logic [ntat_pkg::TIME_W-1:0]             frame_q;

	// table state
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_ptr_q;
	logic [CW-1:0] wr_ptr_q;
	logic [CW-1:0] removed_cnt_q;
	logic          v_s1;

	// nearest-entry search
	logic                        found_q;
	logic [ntat_pkg::DIST_W-1:0] best_q;
	logic [AW-1:0]               best_idx_q;
	logic [AW-1:0]               cmp_idx_q;

	// result
	logic             done_q;
	ntat_pkg::action_t action_q;
	logic [4:0]       slot_q;
	logic [5:0]       removed_q;

	// RAM ports
	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	ntat_pkg::entry_t ram_wdata, ram_rdata, det_entry;

	ntat_pkg::dist_out_t dres;

	logic                 accept;
	logic                 issue;
	logic                 scan_end, purge_end;
	logic                 hit, full;
	logic                 expired;
	logic signed [32:0]   age;
	logic [AW-1:0]        slot_idx;
	logic [AW+4:0]        slot_ext;
	logic [CW+5:0]        count_ext, removed_ext;
	logic [CW-1:0]        count_inc;

	assign accept = start && state_q == ST_IDLE;
	assign busy   = state_q != ST_IDLE;

	// ---------------- register port ----------------
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			ntat_pkg::REG_MATCH_DIST: prdata = {22'd0, md_q};
			ntat_pkg::REG_TRACK_TIME: prdata = {12'd0, tt_q};
			default:                  prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			md_q <= ntat_pkg::MD_RESET;
			tt_q <= ntat_pkg::TT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				ntat_pkg::REG_MATCH_DIST: md_q <= pwdata[ntat_pkg::MD_W-1:0];
				ntat_pkg::REG_TRACK_TIME: tt_q <= pwdata[ntat_pkg::TT_W-1:0];
				default: ;
			endcase
		end
	end

	// squared radius is registered and follows the register in the next cycle
	always_ff @(posedge clk) begin
		md_sq_q <= md_q * md_q;
	end

	// ---------------- command latch ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= opcode;
			pos_x_q   <= pos_x;
			pos_y_q   <= pos_y;
			height_q  <= obj_height;
			heading_q <= heading;
			frame_q   <= frame_time_ms;
		end
	end

	// ---------------- entry memory ----------------
	assign issue     = (state_q == ST_SCAN || state_q == ST_PURGE) && rd_ptr_q < count_q;
	assign ram_re    = issue;
	assign ram_raddr = rd_ptr_q[AW-1:0];

	assign det_entry.x       = pos_x_q;
	assign det_entry.y       = pos_y_q;
	assign det_entry.height  = height_q;
	assign det_entry.heading = heading_q;
	assign det_entry.stamp   = frame_q;

	assign hit  = found_q && best_q < {{(ntat_pkg::DIST_W - ntat_pkg::MDSQ_W){1'b0}}, md_sq_q};
	assign full = count_q >= CW'(TABLE_DEPTH);

	// age is signed: an entry stamped after the purge time is kept
	assign age     = $signed({1'b0, frame_q}) - $signed({1'b0, ram_rdata.stamp});
	assign expired = age > $signed({13'd0, tt_q});

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_ptr_q[AW-1:0];
		ram_wdata = ram_rdata;
		if (state_q == ST_DECIDE) begin
			ram_we    = hit || !full;
			ram_waddr = hit ? best_idx_q : count_q[AW-1:0];
			ram_wdata = det_entry;
		end else if (state_q == ST_PURGE) begin
			ram_we = v_s1 && !expired;
		end
	end

	ntat_ram #(
		.WIDTH ($bits(ntat_pkg::entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// distance pipeline fed from the RAM output
	ntat_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1 && state_q == ST_SCAN),
		.entry_x  (ram_rdata.x),
		.entry_y  (ram_rdata.y),
		.pos_x    (pos_x_q),
		.pos_y    (pos_y_q),
		.res      (dres)
	);

	assign scan_end  = rd_ptr_q == count_q && !v_s1 && !dres.busy;
	assign purge_end = rd_ptr_q == count_q && !v_s1;

	// ---------------- result formatting ----------------
	assign slot_idx    = hit ? best_idx_q : count_q[AW-1:0];
	assign slot_ext    = {5'd0, slot_idx};
	assign count_inc   = count_q + 1'b1;
	assign count_ext   = {6'd0, count_q};
	assign removed_ext = {6'd0, removed_cnt_q};

	assign done        = done_q;
	assign action      = action_q;
	assign slot        = slot_q;
	assign removed     = removed_q;
	assign entry_count = count_ext[5:0];

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			rd_ptr_q      <= '0;
			wr_ptr_q      <= '0;
			removed_cnt_q <= '0;
			v_s1          <= 1'b0;
			found_q       <= 1'b0;
			cmp_idx_q     <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= issue;
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_ptr_q      <= '0;
						wr_ptr_q      <= '0;
						removed_cnt_q <= '0;
						found_q       <= 1'b0;
						cmp_idx_q     <= '0;
						state_q       <= (opcode == ntat_pkg::OP_PURGE) ? ST_PURGE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (dres.valid) begin
						found_q   <= 1'b1;
						cmp_idx_q <= cmp_idx_q + 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!hit && !full) begin
						count_q <= count_inc;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_PURGE: begin
					if (v_s1) begin
						if (expired) begin
							removed_cnt_q <= removed_cnt_q + 1'b1;
						end else begin
							wr_ptr_q <= wr_ptr_q + 1'b1;
						end
					end
					if (purge_end) begin
						count_q <= wr_ptr_q;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// best candidate: strict compare keeps the earliest entry on ties
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && dres.valid && (!found_q || dres.sq_dist < best_q)) begin
			best_q     <= dres.sq_dist;
			best_idx_q <= cmp_idx_q;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE) begin
			removed_q <= 6'd0;
			if (hit) begin
				action_q <= ntat_pkg::ACT_UPDATE;
				slot_q   <= slot_ext[4:0];
			end else if (!full) begin
				action_q <= ntat_pkg::ACT_INSERT;
				slot_q   <= slot_ext[4:0];
			end else begin
				action_q <= ntat_pkg::ACT_DROP;
				slot_q   <= 5'd0;
			end
		end else if (state_q == ST_PURGE && purge_end) begin
			action_q  <= ntat_pkg::ACT_PURGE;
			slot_q    <= 5'd0;
			removed_q <= removed_ext[5:0];
		end
	end

endmodule
